>>> design/ur_pkg.sv
// ----------------------------------------------------------------------------
// ur_pkg: shared types and constants of the uri percent encoder
// Item layout between classifier and serialiser, character sets, hex lookup.
// ----------------------------------------------------------------------------
package ur_pkg;

  // surrogate ranges and utf-8 limits
  localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
  localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [20:0] LIM_ONE      = 21'h00080;
  localparam logic [20:0] LIM_TWO      = 21'h00800;
  localparam logic [20:0] LIM_THREE    = 21'h10000;
  localparam logic [7:0]  LEAD_TWO     = 8'hC0;
  localparam logic [7:0]  LEAD_THREE   = 8'hE0;
  localparam logic [7:0]  LEAD_FOUR    = 8'hF0;
  localparam logic [7:0]  CONT_BYTE    = 8'h80;
  localparam logic [6:0]  PERCENT_CHAR = 7'h25;

  // unescaped punctuation, component set and extra reserved set
  localparam int unsigned NUM_COMP = 9;
  localparam int unsigned NUM_RSVD = 11;
  localparam logic [NUM_COMP-1:0][7:0] COMP_SET = {
    8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29
  };
  localparam logic [NUM_RSVD-1:0][7:0] RSVD_SET = {
    8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B, 8'h24, 8'h2C, 8'h23
  };

  // what a queued item emits
  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_ESC  = 2'd1,
    KIND_ERR  = 2'd2
  } ur_kind_e;

  // one code unit's worth of output, before serialisation
  typedef struct packed {
    ur_kind_e        kind;
    logic [6:0]      pchar;
    logic [3:0][7:0] bytes;
    logic [1:0]      nb_m1;
    logic            eos;
  } ur_item_t;

  // uppercase hex digit for a nibble
  function automatic logic [6:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + {4'd0, n};
    else           c = 8'h37 + {4'd0, n};
    return c[6:0];
  endfunction

endpackage

>>> design/ur_classify.sv
// ----------------------------------------------------------------------------
// ur_classify: code unit classifier and utf-8 byte builder
// Decides passthrough, escape or error per unit and keeps surrogate state.
// ----------------------------------------------------------------------------
module ur_classify import ur_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        keep_reserved_i,
  input  logic        accept_i,
  input  logic [15:0] unit_i,
  input  logic        eos_i,
  output logic        has_item_o,
  output ur_item_t    item_o
);

  logic       high_pending_q, high_pending_d;
  logic [9:0] high_bits_q, high_bits_d;
  logic       discarding_q, discarding_d;

  logic       passes;
  logic       is_low, is_high;
  logic [20:0] cp;

  // passthrough test over letters, digits and the punctuation sets
  always_comb begin
    passes = ((unit_i >= 16'h61) && (unit_i <= 16'h7A)) ||
             ((unit_i >= 16'h41) && (unit_i <= 16'h5A)) ||
             ((unit_i >= 16'h30) && (unit_i <= 16'h39));
    for (int i = 0; i < NUM_COMP; i++) begin
      if (unit_i == {8'd0, COMP_SET[i]}) passes = 1'b1;
    end
    for (int i = 0; i < NUM_RSVD; i++) begin
      if (keep_reserved_i && (unit_i == {8'd0, RSVD_SET[i]})) passes = 1'b1;
    end
  end

  assign is_low  = (unit_i >= LOW_SURR_LO) && (unit_i <= LOW_SURR_HI);
  assign is_high = (unit_i >= HIGH_SURR_LO) && (unit_i <= HIGH_SURR_HI);

  // code point: pair or plain unit
  assign cp = high_pending_q ? (SUPP_BASE + {1'b0, high_bits_q, unit_i[9:0]})
                             : {5'd0, unit_i};

  // decision and next state
  always_comb begin
    high_pending_d = high_pending_q;
    high_bits_d    = high_bits_q;
    discarding_d   = discarding_q;
    has_item_o     = 1'b0;
    item_o.kind    = KIND_ESC;
    item_o.pchar   = unit_i[6:0];
    item_o.eos     = eos_i;
    item_o.bytes   = '0;
    item_o.nb_m1   = 2'd0;

    // utf-8 bytes of the code point
    if (cp < LIM_ONE) begin
      item_o.bytes[0] = cp[7:0];
    end else if (cp < LIM_TWO) begin
      item_o.bytes[0] = LEAD_TWO | {3'd0, cp[10:6]};
      item_o.bytes[1] = CONT_BYTE | {2'd0, cp[5:0]};
      item_o.nb_m1    = 2'd1;
    end else if (cp < LIM_THREE) begin
      item_o.bytes[0] = LEAD_THREE | {4'd0, cp[15:12]};
      item_o.bytes[1] = CONT_BYTE | {2'd0, cp[11:6]};
      item_o.bytes[2] = CONT_BYTE | {2'd0, cp[5:0]};
      item_o.nb_m1    = 2'd2;
    end else begin
      item_o.bytes[0] = LEAD_FOUR | {5'd0, cp[20:18]};
      item_o.bytes[1] = CONT_BYTE | {2'd0, cp[17:12]};
      item_o.bytes[2] = CONT_BYTE | {2'd0, cp[11:6]};
      item_o.bytes[3] = CONT_BYTE | {2'd0, cp[5:0]};
      item_o.nb_m1    = 2'd3;
    end

    if (discarding_q) begin
      // drop until the string ends
      discarding_d = ~eos_i;
    end else if (high_pending_q) begin
      has_item_o     = 1'b1;
      high_pending_d = 1'b0;
      high_bits_d    = '0;
      if (!is_low) begin
        item_o.kind  = KIND_ERR;
        discarding_d = ~eos_i;
      end
    end else if (passes) begin
      has_item_o  = 1'b1;
      item_o.kind = KIND_PASS;
    end else if (is_low) begin
      has_item_o   = 1'b1;
      item_o.kind  = KIND_ERR;
      discarding_d = ~eos_i;
    end else if (is_high) begin
      if (eos_i) begin
        has_item_o  = 1'b1;
        item_o.kind = KIND_ERR;
      end else begin
        high_pending_d = 1'b1;
        high_bits_d    = unit_i[9:0];
      end
    end else begin
      has_item_o = 1'b1;
    end
  end

  // surrogate and discard state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_pending_q <= 1'b0;
      high_bits_q    <= '0;
      discarding_q   <= 1'b0;
    end else if (accept_i) begin
      high_pending_q <= high_pending_d;
      high_bits_q    <= high_bits_d;
      discarding_q   <= discarding_d;
    end
  end

endmodule

>>> design/ur_serial.sv
// ----------------------------------------------------------------------------
// ur_serial: two-slot item queue and character serialiser
// Holds the item being sent and a waiting item; emits a char a cycle if ready.
// ----------------------------------------------------------------------------
module ur_serial import ur_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  ur_item_t   item_i,
  output logic       ready_o,
  output logic       valid_o,
  input  logic       out_ready_i,
  output logic [6:0] char_o,
  output logic       last_of_item_o,
  output logic       string_done_o,
  output logic       error_o
);

  logic     cur_vq, cur_vd, nxt_vq, nxt_vd;
  ur_item_t cur_q, cur_d, nxt_q, nxt_d;
  logic [1:0] byte_q, byte_d, dig_q, dig_d;
  logic     cur_last, cur_free, load_cur;
  logic [7:0] cur_byte;

  assign cur_byte = cur_q.bytes[byte_q];

  // character decode from the current item and position
  always_comb begin
    case (cur_q.kind)
      KIND_PASS: begin
        char_o   = cur_q.pchar;
        cur_last = 1'b1;
      end
      KIND_ESC: begin
        case (dig_q)
          2'd0:    char_o = PERCENT_CHAR;
          2'd1:    char_o = hex_char(cur_byte[7:4]);
          default: char_o = hex_char(cur_byte[3:0]);
        endcase
        cur_last = (dig_q == 2'd2) && (byte_q == cur_q.nb_m1);
      end
      default: begin
        char_o   = '0;
        cur_last = 1'b1;
      end
    endcase
  end

  // an error transaction always closes the string
  assign valid_o        = cur_vq;
  assign last_of_item_o = cur_last;
  assign string_done_o  = cur_last && (cur_q.eos || error_o);
  assign error_o        = (cur_q.kind == KIND_ERR);

  assign cur_free = !cur_vq || (out_ready_i && cur_last);
  assign ready_o  = !nxt_vq || cur_free;

  // slot movement
  always_comb begin
    cur_vd   = cur_vq;
    cur_d    = cur_q;
    nxt_vd   = nxt_vq;
    nxt_d    = nxt_q;
    load_cur = 1'b0;
    if (load_i) begin
      if (nxt_vq) begin
        cur_d    = nxt_q;
        cur_vd   = 1'b1;
        nxt_d    = item_i;
        load_cur = 1'b1;
      end else if (cur_free) begin
        cur_d    = item_i;
        cur_vd   = 1'b1;
        load_cur = 1'b1;
      end else begin
        nxt_d  = item_i;
        nxt_vd = 1'b1;
      end
    end else if (cur_free) begin
      if (nxt_vq) begin
        cur_d    = nxt_q;
        cur_vd   = 1'b1;
        nxt_vd   = 1'b0;
        load_cur = 1'b1;
      end else begin
        cur_vd = 1'b0;
      end
    end
  end

  // position within the escaped bytes
  always_comb begin
    byte_d = byte_q;
    dig_d  = dig_q;
    if (load_cur) begin
      byte_d = '0;
      dig_d  = '0;
    end else if (cur_vq && out_ready_i && !cur_last) begin
      if (dig_q == 2'd2) begin
        dig_d  = '0;
        byte_d = byte_q + 2'd1;
      end else begin
        dig_d = dig_q + 2'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vq <= 1'b0;
      nxt_vq <= 1'b0;
      byte_q <= '0;
      dig_q  <= '0;
    end else begin
      cur_vq <= cur_vd;
      nxt_vq <= nxt_vd;
      byte_q <= byte_d;
      dig_q  <= dig_d;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    nxt_q <= nxt_d;
  end

  // checks
  a_nxt_needs_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nxt_vq |-> cur_vq) else $error("waiting item without a current item");

  a_dig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vq |-> (dig_q != 2'd3)) else $error("digit position out of range");

  a_single_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_vq && (cur_q.kind != KIND_ESC)) |-> (byte_q == 2'd0 && dig_q == 2'd0))
    else $error("single-character item not at start position");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_vq && error_o) |-> (string_done_o || !cur_q.eos) && last_of_item_o &&
    (char_o == 7'd0)) else $error("malformed error transaction");

endmodule

>>> design/uri_percent_utf8_encoder.sv
// ----------------------------------------------------------------------------
// uri_percent_utf8_encoder: uri percent encoder over utf-16 code units
// Passes unreserved characters, escapes others as utf-8 percent triplets.
//
//   channel   dir  tdata             tuser                        tlast
//   s_axis    in   [15:0] code_unit  -                            end_of_string
//   m_axis    out  [6:0] out_char    [0] last_of_item, [1] error  string_done
//   cfg       in   cfg_wdata_i = keep_reserved, written when cfg_we_i is high
//
// One output character per cycle unless m_axis stalls: a unit gives one
// character if passed through, 3 per utf-8 byte if escaped (3 to 12), set by
// the single character port. A held high surrogate or a dropped unit is
// accepted and gives no output. Input stalls while an item waits behind the
// one being sent, until the current item's last character is taken.
// Reset clears surrogate and discard state, the item queue and keep_reserved.
// ----------------------------------------------------------------------------
module uri_percent_utf8_encoder import ur_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] code_unit
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [6:0] out_char, [7] zero
  output logic [1:0]  m_axis_tuser_o,   // [0] last_of_item, [1] error
  output logic        m_axis_tlast_o
);

  logic     keep_reserved_q;
  logic     accept, has_item;
  ur_item_t item;
  logic [6:0] out_char;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_reserved_q <= 1'b0;
    end else if (cfg_we_i) begin
      keep_reserved_q <= cfg_wdata_i;
    end
  end

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // classification of each accepted transaction
  ur_classify u_classify (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .keep_reserved_i (keep_reserved_q),
    .accept_i        (accept),
    .unit_i          (s_axis_tdata_i),
    .eos_i           (s_axis_tlast_i),
    .has_item_o      (has_item),
    .item_o          (item)
  );

  // character serialiser
  ur_serial u_serial (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept && has_item),
    .item_i         (item),
    .ready_o        (s_axis_tready_o),
    .valid_o        (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .char_o         (out_char),
    .last_of_item_o (m_axis_tuser_o[0]),
    .string_done_o  (m_axis_tlast_o),
    .error_o        (m_axis_tuser_o[1])
  );

  assign m_axis_tdata_o = {1'b0, out_char};

endmodule

>>> tb/uri_escape_check.sv
// ----------------------------------------------------------------------------
// uri_escape_check: predicts and checks the percent-encoded character stream
// Watches the unit and character channels and the mode register. Every
// accepted code unit is expanded into the characters it should cause. Every
// accepted character is compared field by field against the oldest of these.
// ----------------------------------------------------------------------------
module uri_escape_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        unit_valid_i,
  input  logic        unit_ready_i,
  input  logic [15:0] unit_data_i,    // [15:0] code_unit
  input  logic        unit_last_i,    // end_of_string
  input  logic        char_valid_i,
  input  logic        char_ready_i,
  input  logic [7:0]  char_data_i,    // [6:0] out_char, [7] zero
  input  logic [1:0]  char_user_i,    // [0] last_of_item, [1] error
  input  logic        char_last_i,    // string_done
  output int unsigned mismatches_o,
  output int unsigned chars_due_o
);

  localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
  localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;
  localparam logic [6:0]  PERCENT       = 7'h25;

  // one character of the expected output stream
  typedef struct packed {
    logic [6:0] ch;
    logic       unit_end;
    logic       str_end;
    logic       bad;
  } enc_char_t;

  enc_char_t   chars_due[$];
  logic        keep_rsvd;
  logic        held;
  logic [9:0]  held_bits;
  logic        dropping;
  int unsigned chars_seen;

  initial mismatches_o = 0;
  initial chars_due_o  = 0;

  // uppercase hex digit of a nibble
  function automatic logic [6:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) return 7'h30 + {3'b000, n};
    return 7'h37 + {3'b000, n};
  endfunction

  // letters, digits and the selected unescaped punctuation
  function automatic logic is_plain(input logic [15:0] u, input logic rsvd);
    logic plain;
    plain = (u >= 16'h61 && u <= 16'h7A) || (u >= 16'h41 && u <= 16'h5A) ||
            (u >= 16'h30 && u <= 16'h39);
    case (u)
      // - _ . ! ~ * ' ( )
      16'h2D, 16'h5F, 16'h2E, 16'h21, 16'h7E, 16'h2A, 16'h27, 16'h28, 16'h29:
        plain = 1'b1;
      // ; / ? : @ & = + $ , #
      16'h3B, 16'h2F, 16'h3F, 16'h3A, 16'h40, 16'h26, 16'h3D, 16'h2B, 16'h24,
      16'h2C, 16'h23:
        if (rsvd) plain = 1'b1;
      default: ;
    endcase
    return plain;
  endfunction

  task automatic push_char(input logic [6:0] ch, input logic ue, input logic se,
                           input logic bad);
    enc_char_t c;
    c.ch       = ch;
    c.unit_end = ue;
    c.str_end  = se;
    c.bad      = bad;
    chars_due.push_back(c);
  endtask

  // malformed surrogate use: single error character, drop rest of string
  task automatic push_error(input logic eos);
    push_char(7'h00, 1'b1, 1'b1, 1'b1);
    held      = 1'b0;
    held_bits = '0;
    dropping  = !eos;
  endtask

  // utf-8 bytes of a code point, each as a percent triplet
  task automatic push_escaped(input logic [20:0] cp, input logic eos);
    logic [7:0] utf [4];
    int         nb;
    logic       tail;
    if (cp < 21'h80) begin
      utf[0] = cp[7:0];
      nb = 1;
    end else if (cp < 21'h800) begin
      utf[0] = 8'hC0 | {3'b000, cp[10:6]};
      utf[1] = 8'h80 | {2'b00, cp[5:0]};
      nb = 2;
    end else if (cp < 21'h10000) begin
      utf[0] = 8'hE0 | {4'b0000, cp[15:12]};
      utf[1] = 8'h80 | {2'b00, cp[11:6]};
      utf[2] = 8'h80 | {2'b00, cp[5:0]};
      nb = 3;
    end else begin
      utf[0] = 8'hF0 | {5'b00000, cp[20:18]};
      utf[1] = 8'h80 | {2'b00, cp[17:12]};
      utf[2] = 8'h80 | {2'b00, cp[11:6]};
      utf[3] = 8'h80 | {2'b00, cp[5:0]};
      nb = 4;
    end
    for (int i = 0; i < nb; i++) begin
      tail = (i == nb - 1);
      push_char(PERCENT, 1'b0, 1'b0, 1'b0);
      push_char(nibble_char(utf[i][7:4]), 1'b0, 1'b0, 1'b0);
      push_char(nibble_char(utf[i][3:0]), tail, tail && eos, 1'b0);
    end
  endtask

  // expected characters caused by one code unit
  task automatic encode_unit(input logic [15:0] u, input logic eos);
    if (dropping) begin
      if (eos) dropping = 1'b0;
      return;
    end
    if (held) begin
      // unit after a held high surrogate is taken raw
      if (u < LO_SURR_FIRST || u > LO_SURR_LAST) begin
        push_error(eos);
        return;
      end
      push_escaped(21'h10000 + {1'b0, held_bits, u[9:0]}, eos);
      held      = 1'b0;
      held_bits = '0;
    end else if (is_plain(u, keep_rsvd)) begin
      push_char(u[6:0], 1'b1, eos, 1'b0);
    end else if (u >= LO_SURR_FIRST && u <= LO_SURR_LAST) begin
      push_error(eos);
    end else if (u >= HI_SURR_FIRST && u <= HI_SURR_LAST) begin
      if (eos) begin
        push_error(eos);
      end else begin
        held      = 1'b1;
        held_bits = u[9:0];
      end
    end else begin
      push_escaped({5'b00000, u}, eos);
    end
  endtask

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("mismatch: char %0d field %s got 0x%0h want 0x%0h",
             chars_seen, what, got, want);
    mismatches_o++;
  endtask

  // predict on accepted units, compare accepted characters
  always @(posedge clk_i or negedge rst_ni) begin
    enc_char_t want;
    if (!rst_ni) begin
      keep_rsvd  = 1'b0;
      held       = 1'b0;
      held_bits  = '0;
      dropping   = 1'b0;
      chars_seen = 0;
      chars_due.delete();
    end else begin
      if (unit_valid_i && unit_ready_i) encode_unit(unit_data_i, unit_last_i);
      if (char_valid_i && char_ready_i) begin
        if (chars_due.size() == 0) begin
          flag_mismatch("unexpected", 32'(char_data_i), 32'd0);
        end else begin
          want = chars_due.pop_front();
          if (char_data_i != {1'b0, want.ch})
            flag_mismatch("out_char", 32'(char_data_i), 32'(want.ch));
          if (char_user_i[0] != want.unit_end)
            flag_mismatch("last_of_item", 32'(char_user_i[0]), 32'(want.unit_end));
          if (char_last_i != want.str_end)
            flag_mismatch("string_done", 32'(char_last_i), 32'(want.str_end));
          if (char_user_i[1] != want.bad)
            flag_mismatch("error", 32'(char_user_i[1]), 32'(want.bad));
        end
        chars_seen++;
      end
      if (cfg_we_i) keep_rsvd = cfg_wdata_i;
    end
    chars_due_o = chars_due.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the uri percent utf-8 encoder
// Drives strings of code units under both punctuation modes: directed edge
// cases first, then random strings with well-formed pairs and broken ones.
// Both sides stall in random bursts; the checker gives the failure count.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic        MODE_COMP    = 1'b0;
  localparam logic        MODE_RSVD    = 1'b1;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_valid   = 1'b0;
  logic        s_ready;
  logic [15:0] s_data    = '0;
  logic        s_last    = 1'b0;
  logic        m_valid;
  logic        m_ready   = 1'b0;
  logic [7:0]  m_data;
  logic [1:0]  m_user;
  logic        m_last;

  int unsigned mismatches;
  int unsigned chars_due;
  int unsigned units_sent = 0;
  int unsigned quiet      = 0;
  int unsigned stall_left = 0;
  logic        idle_on    = 1'b1;

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  uri_percent_utf8_encoder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  uri_escape_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .unit_valid_i (s_valid),
    .unit_ready_i (s_ready),
    .unit_data_i  (s_data),
    .unit_last_i  (s_last),
    .char_valid_i (m_valid),
    .char_ready_i (m_ready),
    .char_data_i  (m_data),
    .char_user_i  (m_user),
    .char_last_i  (m_last),
    .mismatches_o (mismatches),
    .chars_due_o  (chars_due)
  );

  // output back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_ready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_ready = 1'b0;
      stall_left = $urandom_range(1, 7) - 1;
    end else begin
      m_ready = 1'b1;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n && !((s_valid && s_ready) || (m_valid && m_ready))) quiet++;
    else quiet = 0;
    if (quiet == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one code unit, with an occasional gap before it
  task automatic send_unit(input logic [15:0] u, input logic eos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_valid = 1'b0;
      s_data  = 16'($urandom);
      s_last  = 1'($urandom);
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_valid = 1'b1;
    s_data  = u;
    s_last  = eos;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
    units_sent++;
  endtask

  // let the block drain before a mode change
  task automatic settle();
    s_valid = 1'b0;
    while (chars_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_we    = 1'b1;
    cfg_wdata = mode;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [15:0] pick_unit();
    logic [15:0] u;
    case ($urandom_range(0, 9))
      0, 1, 2: u = 16'($urandom_range(16'h20, 16'h7E));
      3:       u = 16'($urandom_range(16'h00, 16'h7F));
      4:       u = 16'($urandom_range(16'h80, 16'h7FF));
      5:       u = 16'($urandom_range(16'h800, 16'hD7FF));
      6:       u = 16'($urandom_range(16'hE000, 16'hFFFF));
      7:       u = 16'($urandom);
      default: begin
        case ($urandom_range(0, 2))
          0:       u = 16'($urandom_range(16'h61, 16'h7A));
          1:       u = 16'($urandom_range(16'h41, 16'h5A));
          default: u = 16'($urandom_range(16'h30, 16'h39));
        endcase
      end
    endcase
    return u;
  endfunction

  // a random string: mostly valid units and pairs, some broken surrogates
  task automatic send_string();
    int unsigned len;
    int unsigned k;
    int unsigned roll;
    len  = $urandom_range(1, 6);
    k    = 0;
    while (k < len) begin
      roll = $urandom_range(0, 19);
      if (roll < 4 && k + 1 < len) begin
        send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
        send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), k + 2 == len);
        k += 2;
      end else begin
        if (roll == 4)
          send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), k + 1 == len);
        else if (roll == 5)
          send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), k + 1 == len);
        else
          send_unit(pick_unit(), k + 1 == len);
        k++;
      end
    end
  endtask

  task automatic send_random(input int unsigned upto, input logic vary_idle);
    while (units_sent < upto) begin
      if (vary_idle) idle_on = ($urandom_range(0, 4) != 0);
      send_string();
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // component mode: passthrough, escapes of every length, surrogate cases
    write_mode(MODE_COMP);
    send_unit(16'h0061, 1'b0);
    send_unit(16'h0030, 1'b0);
    send_unit(16'h002D, 1'b0);
    send_unit(16'h003B, 1'b0);    // reserved char, escaped in this mode
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'hD800, 1'b0);    // lowest pair
    send_unit(16'hDC00, 1'b1);
    send_unit(16'hDBFF, 1'b0);    // highest pair
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hDC00, 1'b0);    // lone low, then rest of string dropped
    send_unit(16'h0061, 1'b0);
    send_unit(16'h0041, 1'b1);
    send_unit(16'hD83D, 1'b1);    // high surrogate ending the string
    send_unit(16'hD800, 1'b0);    // high followed by a plain letter
    send_unit(16'h0061, 1'b0);
    send_unit(16'h0062, 1'b1);
    send_unit(16'hDBFF, 1'b0);    // high followed by another high
    send_unit(16'hD800, 1'b1);
    send_unit(16'hDFFF, 1'b1);    // lone low ending the string
    settle();

    // full-uri mode: reserved chars pass, percent itself is escaped
    write_mode(MODE_RSVD);
    send_unit(16'h003B, 1'b0);
    send_unit(16'h0023, 1'b0);
    send_unit(16'h0025, 1'b0);
    send_unit(16'h007E, 1'b1);
    send_random(130, 1'b1);
    settle();

    write_mode(MODE_COMP);
    send_random(240, 1'b1);
    settle();

    write_mode(MODE_RSVD);
    idle_on = 1'b1;
    send_random(310, 1'b0);

    // last part without any stalls
    idle_on = 1'b0;
    send_random(350, 1'b0);
    s_valid = 1'b0;

    while (chars_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && chars_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
design/ur_pkg.sv
design/ur_classify.sv
design/ur_serial.sv
design/uri_percent_utf8_encoder.sv
tb/uri_escape_check.sv
tb/tb_top.sv
